// ===== sv/spill_register_cache_top_defines.svh =====
// Assertion macros shared by the spill register cache modules.
// Each macro expects a clk and an active-high rst in the scope where it is used.
`ifndef SPILL_REGISTER_CACHE_TOP_DEFINES_SVH
`define SPILL_REGISTER_CACHE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Clocked check that is switched off while reset is high.
`define SRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds while reset is high.
`define SRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SRC_ASSERT(lbl, prop, msg)
`define SRC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== sv/src_pkg.sv =====
package src_pkg;

  // Fixed geometry of the cache and of the stream fields.
  localparam int TEMP_ENTRIES  = 2;
  localparam int SLOT_BITS_DEF = 10;
  localparam int INDEX_W       = 10;
  localparam int REG_W         = 5;
  localparam int OFF_W         = 12;
  localparam int OP_W          = 3;
  localparam int KIND_W        = 2;
  localparam int CFG_IDX_W     = 1;
  localparam int IN_DATA_W     = 32;
  localparam int OUT_DATA_W    = 40;

  // Register numbers that back the two entries after reset.
  localparam logic [REG_W-1:0] TEMP_ZERO_RST = 5'd0;
  localparam logic [REG_W-1:0] TEMP_ONE_RST  = 5'd1;

  typedef enum logic [OP_W-1:0] {
    OP_MAP_SRC    = 3'd0,
    OP_MAP_DST    = 3'd1,
    OP_MAP_PAIR   = 3'd2,
    OP_WB_ALL     = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_DIRTY_TEMP = 3'd5,
    OP_DIRTY_REG  = 3'd6
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_STORE  = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_ANSWER = 2'd2,
    KIND_DONE   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_ZERO = 1'd0,
    CFG_TEMP_ONE  = 1'd1
  } cfg_idx_t;

  // Controller states; each non-idle state presents one result.
  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_STORE0 = 3'd1,
    S_LOAD0  = 3'd2,
    S_STORE1 = 3'd3,
    S_LOAD1  = 3'd4,
    S_FINAL  = 3'd5
  } state_t;

  // Spill accesses an item needs, in the order they are sent.
  typedef struct packed {
    logic st0;
    logic ld0;
    logic st1;
    logic ld1;
  } steps_t;

  // Controller to datapath.
  typedef struct packed {
    logic   take;
    logic   commit;
    state_t sel;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    steps_t plan_in;
    steps_t plan;
  } status_t;

endpackage

// ===== sv/src_dp.sv =====
`include "spill_register_cache_top_defines.svh"

module src_dp #(
  parameter int SLOT_BITS = src_pkg::SLOT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [src_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [src_pkg::REG_W-1:0]      cfg_data,
  input  logic [src_pkg::OP_W-1:0]       operation,
  input  logic                           first_spilled,
  input  logic [src_pkg::INDEX_W-1:0]    first_index,
  input  logic                           first_load,
  input  logic                           second_spilled,
  input  logic [src_pkg::INDEX_W-1:0]    second_index,
  input  logic                           second_load,
  input  logic                           temp_select,
  input  logic [src_pkg::REG_W-1:0]      reg_number,
  input  src_pkg::cmd_t                  cmd,
  output src_pkg::status_t               status,
  output logic [src_pkg::KIND_W-1:0]     kind,
  output logic [src_pkg::REG_W-1:0]      mem_reg,
  output logic [src_pkg::OFF_W-1:0]      mem_offset,
  output logic [src_pkg::INDEX_W-1:0]    first_result,
  output logic [src_pkg::INDEX_W-1:0]    second_result
);
  import src_pkg::*;

  // Slot bits that an operand index can actually carry.
  localparam int SRC_W = (SLOT_BITS < INDEX_W) ? SLOT_BITS : INDEX_W;

  // Configuration and cache state.
  logic [REG_W-1:0]        temp_reg   [TEMP_ENTRIES];
  logic [TEMP_ENTRIES-1:0] entry_used;
  logic [TEMP_ENTRIES-1:0] entry_dirty;
  logic [SLOT_BITS-1:0]    entry_slot [TEMP_ENTRIES];

  // Plan of the item in flight, captured at the input transfer.
  steps_t                  plan;
  logic [SLOT_BITS-1:0]    plan_slot  [TEMP_ENTRIES];
  kind_t                   plan_kind;
  logic [INDEX_W-1:0]      plan_r1;
  logic [INDEX_W-1:0]      plan_r2;
  logic [TEMP_ENTRIES-1:0] plan_used;
  logic [TEMP_ENTRIES-1:0] plan_dirty;
  logic [SLOT_BITS-1:0]    plan_eslot [TEMP_ENTRIES];

  // Decision logic.
  op_t                     op_in;
  logic [SLOT_BITS-1:0]    slot_a;
  logic [SLOT_BITS-1:0]    slot_b;
  logic [TEMP_ENTRIES-1:0] hit_a;
  logic [TEMP_ENTRIES-1:0] hit_b;
  logic                    miss_a;
  logic                    miss_b;
  logic                    ea;
  logic                    eb;
  logic                    victim;
  logic                    sgl_act;
  logic                    sgl_is_b;
  logic                    sgl_hit;
  logic                    sgl_e;
  logic                    sgl_load;
  logic [SLOT_BITS-1:0]    sgl_slot;
  logic [TEMP_ENTRIES-1:0] repl;
  logic [TEMP_ENTRIES-1:0] nload;
  logic [TEMP_ENTRIES-1:0] set_dirty;
  logic [SLOT_BITS-1:0]    nslot      [TEMP_ENTRIES];
  logic                    wb;
  logic                    clr;
  kind_t                   kind_d;
  logic [INDEX_W-1:0]      r1_d;
  logic [INDEX_W-1:0]      r2_d;
  logic [TEMP_ENTRIES-1:0] st_d;
  logic [TEMP_ENTRIES-1:0] ld_d;
  logic [TEMP_ENTRIES-1:0] used_next;
  logic [TEMP_ENTRIES-1:0] dirty_next;
  logic [SLOT_BITS-1:0]    slot_next  [TEMP_ENTRIES];

  // Lookup of both operands and the single-operand victim choice.
  always_comb begin
    op_in    = op_t'(operation);
    slot_a   = SLOT_BITS'(first_index[SRC_W-1:0]);
    slot_b   = SLOT_BITS'(second_index[SRC_W-1:0]);
    for (int e = 0; e < TEMP_ENTRIES; e++) begin
      hit_a[e] = entry_used[e] && (entry_slot[e] == slot_a);
      hit_b[e] = entry_used[e] && (entry_slot[e] == slot_b);
    end
    miss_a   = !hit_a[0] && !hit_a[1];
    miss_b   = !hit_b[0] && !hit_b[1];
    ea       = !hit_a[0];
    eb       = !hit_b[0];
    victim   = !entry_dirty[1];
    sgl_is_b = (op_in == OP_MAP_PAIR) && !first_spilled && second_spilled;
    sgl_slot = sgl_is_b ? slot_b : slot_a;
    sgl_hit  = sgl_is_b ? !miss_b : !miss_a;
    sgl_e    = sgl_hit ? (sgl_is_b ? eb : ea) : victim;
  end

  // Per-operation plan: replacements, dirty marks and the final answer.
  always_comb begin
    repl      = '0;
    nload     = '0;
    set_dirty = '0;
    nslot[0]  = slot_a;
    nslot[1]  = slot_b;
    wb        = 1'b0;
    clr       = 1'b0;
    sgl_act   = 1'b0;
    sgl_load  = 1'b0;
    kind_d    = KIND_DONE;
    r1_d      = '0;
    r2_d      = '0;
    unique case (op_in)
      OP_MAP_SRC, OP_MAP_DST: begin
        kind_d   = KIND_ANSWER;
        r1_d     = first_index;
        sgl_act  = first_spilled;
        sgl_load = (op_in == OP_MAP_SRC);
        if (first_spilled) begin
          r1_d = INDEX_W'(temp_reg[sgl_e]);
          set_dirty[sgl_e] = (op_in == OP_MAP_DST);
        end
      end
      OP_MAP_PAIR: begin
        kind_d = KIND_ANSWER;
        r1_d   = first_index;
        r2_d   = second_index;
        if (first_spilled && second_spilled && (slot_a == slot_b)) begin
          // Both operands name one slot: a single lookup serves both.
          sgl_act  = 1'b1;
          sgl_load = first_load || second_load;
          r1_d     = INDEX_W'(temp_reg[sgl_e]);
          r2_d     = INDEX_W'(temp_reg[sgl_e]);
        end else if (first_spilled && second_spilled) begin
          priority if (miss_a && !miss_b) begin
            repl[!eb]  = 1'b1;
            nload[!eb] = first_load;
            nslot[!eb] = slot_a;
            r1_d       = INDEX_W'(temp_reg[!eb]);
            r2_d       = INDEX_W'(temp_reg[eb]);
          end else if (!miss_a && miss_b) begin
            repl[!ea]  = 1'b1;
            nload[!ea] = second_load;
            nslot[!ea] = slot_b;
            r1_d       = INDEX_W'(temp_reg[ea]);
            r2_d       = INDEX_W'(temp_reg[!ea]);
          end else if (miss_a && miss_b) begin
            repl  = '1;
            nload = {second_load, first_load};
            r1_d  = INDEX_W'(temp_reg[0]);
            r2_d  = INDEX_W'(temp_reg[1]);
          end else begin
            r1_d = INDEX_W'(temp_reg[ea]);
            r2_d = INDEX_W'(temp_reg[eb]);
          end
        end else if (first_spilled) begin
          sgl_act  = 1'b1;
          sgl_load = first_load;
          r1_d     = INDEX_W'(temp_reg[sgl_e]);
        end else if (second_spilled) begin
          sgl_act  = 1'b1;
          sgl_load = second_load;
          r2_d     = INDEX_W'(temp_reg[sgl_e]);
        end
      end
      OP_WB_ALL: wb = 1'b1;
      OP_CLEAR: clr = 1'b1;
      OP_DIRTY_TEMP: set_dirty[temp_select] = 1'b1;
      OP_DIRTY_REG: begin
        // A register that backs neither entry marks nothing.
        priority if (temp_reg[0] == reg_number) begin
          set_dirty[0] = 1'b1;
        end else if (temp_reg[1] == reg_number) begin
          set_dirty[1] = 1'b1;
        end else begin
          set_dirty = '0;
        end
      end
      default: kind_d = KIND_DONE;
    endcase
    // A single-operand miss replaces the chosen entry.
    if (sgl_act && !sgl_hit) begin
      repl[sgl_e]  = 1'b1;
      nload[sgl_e] = sgl_load;
      nslot[sgl_e] = sgl_slot;
    end
  end

  // Spill accesses and the entry state after the item.
  always_comb begin
    for (int e = 0; e < TEMP_ENTRIES; e++) begin
      st_d[e]       = entry_used[e] && entry_dirty[e] && (repl[e] || wb);
      ld_d[e]       = repl[e] && nload[e];
      used_next[e]  = repl[e] || entry_used[e];
      slot_next[e]  = repl[e] ? nslot[e] : entry_slot[e];
      dirty_next[e] = entry_dirty[e];
      if (repl[e] || st_d[e]) begin
        dirty_next[e] = 1'b0;
      end
      if (set_dirty[e]) begin
        dirty_next[e] = 1'b1;
      end
      if (clr) begin
        used_next[e]  = 1'b0;
        slot_next[e]  = '0;
        dirty_next[e] = 1'b0;
      end
    end
    status.plan_in = '{st0: st_d[0], ld0: ld_d[0], st1: st_d[1], ld1: ld_d[1]};
    status.plan    = plan;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_reg[0] <= TEMP_ZERO_RST;
      temp_reg[1] <= TEMP_ONE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TEMP_ZERO: temp_reg[0] <= cfg_data;
        CFG_TEMP_ONE:  temp_reg[1] <= cfg_data;
        default:       temp_reg[0] <= temp_reg[0];
      endcase
    end
  end

  // Cache state is updated when the final result is transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_used  <= '0;
      entry_dirty <= '0;
      for (int e = 0; e < TEMP_ENTRIES; e++) begin
        entry_slot[e] <= '0;
      end
    end else if (cmd.commit) begin
      entry_used  <= plan_used;
      entry_dirty <= plan_dirty;
      for (int e = 0; e < TEMP_ENTRIES; e++) begin
        entry_slot[e] <= plan_eslot[e];
      end
    end
  end

  // Plan capture at the input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      plan <= '0;
    end else if (cmd.take) begin
      plan <= status.plan_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      plan_kind  <= kind_d;
      plan_r1    <= r1_d;
      plan_r2    <= r2_d;
      plan_used  <= used_next;
      plan_dirty <= dirty_next;
      for (int e = 0; e < TEMP_ENTRIES; e++) begin
        plan_slot[e]  <= nslot[e];
        plan_eslot[e] <= slot_next[e];
      end
    end
  end

  // Result fields for the step the controller presents.
  always_comb begin
    kind          = KIND_DONE;
    mem_reg       = '0;
    mem_offset    = '0;
    first_result  = '0;
    second_result = '0;
    unique case (cmd.sel)
      S_STORE0: begin
        kind       = KIND_STORE;
        mem_reg    = temp_reg[0];
        mem_offset = OFF_W'({entry_slot[0][SRC_W-1:0], 2'b00});
      end
      S_LOAD0: begin
        kind       = KIND_LOAD;
        mem_reg    = temp_reg[0];
        mem_offset = OFF_W'({plan_slot[0][SRC_W-1:0], 2'b00});
      end
      S_STORE1: begin
        kind       = KIND_STORE;
        mem_reg    = temp_reg[1];
        mem_offset = OFF_W'({entry_slot[1][SRC_W-1:0], 2'b00});
      end
      S_LOAD1: begin
        kind       = KIND_LOAD;
        mem_reg    = temp_reg[1];
        mem_offset = OFF_W'({plan_slot[1][SRC_W-1:0], 2'b00});
      end
      S_FINAL: begin
        kind          = plan_kind;
        first_result  = plan_r1;
        second_result = plan_r2;
      end
      default: kind = KIND_DONE;
    endcase
  end

  // A store is only presented for an entry that holds dirty data.
  `SRC_ASSERT(a_store0_dirty, (cmd.sel == S_STORE0) |-> (entry_used[0] && entry_dirty[0]), "store of clean entry 0")
  `SRC_ASSERT(a_store1_dirty, (cmd.sel == S_STORE1) |-> (entry_used[1] && entry_dirty[1]), "store of clean entry 1")
  // A load always fills an entry that stays in use.
  `SRC_ASSERT(a_load_fills, ((cmd.sel == S_LOAD0) |-> plan_used[0]) and ((cmd.sel == S_LOAD1) |-> plan_used[1]), "load into unused entry")

endmodule

// ===== sv/src_ctrl.sv =====
`include "spill_register_cache_top_defines.svh"

module src_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic             m_tlast,
  input  src_pkg::status_t status,
  output src_pkg::cmd_t    cmd
);
  import src_pkg::*;

  state_t state;
  state_t state_next;
  steps_t rest;

  // First result still owed, in the fixed order store0, load0, store1, load1.
  function automatic state_t pick(steps_t s);
    state_t r;
    priority if (s.st0) r = S_STORE0;
    else if (s.ld0)     r = S_LOAD0;
    else if (s.st1)     r = S_STORE1;
    else if (s.ld1)     r = S_LOAD1;
    else                r = S_FINAL;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    rest       = status.plan;
    state_next = state;
    s_tready   = (state == S_IDLE);
    m_tvalid   = (state != S_IDLE);
    m_tlast    = (state == S_FINAL);
    cmd.take   = s_tvalid && (state == S_IDLE);
    cmd.commit = (state == S_FINAL) && m_tready;
    cmd.sel    = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = pick(status.plan_in);
        end
      end
      S_STORE0: begin
        rest.st0 = 1'b0;
        if (m_tready) state_next = pick(rest);
      end
      S_LOAD0: begin
        rest.st0 = 1'b0;
        rest.ld0 = 1'b0;
        if (m_tready) state_next = pick(rest);
      end
      S_STORE1: begin
        rest.st0 = 1'b0;
        rest.ld0 = 1'b0;
        rest.st1 = 1'b0;
        if (m_tready) state_next = pick(rest);
      end
      S_LOAD1: begin
        if (m_tready) state_next = S_FINAL;
      end
      S_FINAL: begin
        if (m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // An accepted item always produces a result in the next cycle.
  `SRC_ASSERT(a_take_then_result, cmd.take |=> m_tvalid, "no result after input transfer")
  // The final transfer returns the block to accepting input.
  `SRC_ASSERT(a_final_then_idle, cmd.commit |=> s_tready, "not idle after final transfer")
  // Input is never taken while a result is pending.
  `SRC_ASSERT_ALWAYS(a_one_item, !(cmd.take && m_tvalid), "input taken during result")

endmodule

// ===== sv/spill_register_cache_top.sv =====
// Channel   | Direction | Handshake           | Payload
// s_*       | in        | s_tvalid / s_tready | s_tdata operands, s_tuser operation
// m_*       | out       | m_tvalid / m_tready | m_tdata fields, m_tuser kind, m_tlast
// cfg_*     | in        | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
// An item has an input transfer and then one transfer per result: the stores
// and loads that it needs, then its final result; a pair miss may store and load
// both entries. The controller emits one result per cycle while m_tready is high.
// Reset (rst, synchronous) empties both entries and restores the temp registers.
// A stall on m_tready holds the current result; no input is taken until the
// final result of the item has been transferred.

module spill_register_cache_top #(
  parameter int SLOT_BITS = src_pkg::SLOT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [src_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [src_pkg::REG_W-1:0]         cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // first_spilled, first_index, first_load, second_spilled, second_index,
  // second_load, temp_select, reg_number, zero fill
  input  logic [src_pkg::IN_DATA_W-1:0]     s_tdata,
  // operation
  input  logic [src_pkg::OP_W-1:0]          s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // mem_reg, mem_offset, first_result, second_result, zero fill
  output logic [src_pkg::OUT_DATA_W-1:0]    m_tdata,
  // kind
  output logic [src_pkg::KIND_W-1:0]        m_tuser,
  output logic                              m_tlast
);
  import src_pkg::*;

  cmd_t               cmd;
  status_t            status;
  logic [REG_W-1:0]   mem_reg;
  logic [OFF_W-1:0]   mem_offset;
  logic [INDEX_W-1:0] first_result;
  logic [INDEX_W-1:0] second_result;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  src_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .status   (status),
    .cmd      (cmd)
  );

  src_dp #(
    .SLOT_BITS (SLOT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .operation      (s_tuser),
    .first_spilled  (s_tdata[0]),
    .first_index    (s_tdata[10:1]),
    .first_load     (s_tdata[11]),
    .second_spilled (s_tdata[12]),
    .second_index   (s_tdata[22:13]),
    .second_load    (s_tdata[23]),
    .temp_select    (s_tdata[24]),
    .reg_number     (s_tdata[29:25]),
    .cmd            (cmd),
    .status         (status),
    .kind           (m_tuser),
    .mem_reg        (mem_reg),
    .mem_offset     (mem_offset),
    .first_result   (first_result),
    .second_result  (second_result)
  );

  // Result packing, lowest field first.
  assign m_tdata = {3'b000, second_result, first_result, mem_offset, mem_reg};

endmodule
